FILE: src/cosine_dissimilarity_engine_macros.svh
// ----------------------------------------------------------------------------
// cosine_dissimilarity_engine_macros
// Assertion macros used by the checker of the engine.
// ----------------------------------------------------------------------------
`ifndef COSINE_DISSIMILARITY_ENGINE_MACROS_SVH
`define COSINE_DISSIMILARITY_ENGINE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define CDE_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CDE_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg
// Types and constants shared by the controller and datapath of the engine.
// ----------------------------------------------------------------------------
package cde_pkg;

    localparam int ELEM_W     = 16;
    localparam int DOT_W      = 42;
    localparam int NORM_W     = 41;
    localparam int SQ_SHIFT   = 20;
    localparam int SQ_W       = NORM_W + SQ_SHIFT;          // 61
    localparam int ROOT_W     = (SQ_W + 1) / 2;             // 31
    localparam int DEN_W      = 2 * ROOT_W;                 // 62
    localparam int QUO_W      = 17;
    localparam int PRE_SHIFT  = 36 - QUO_W;                 // 19
    localparam int REM_W      = DEN_W + 1;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQ_LOAD1,
        ST_SQ_RUN1,
        ST_SQ_LOAD2,
        ST_SQ_RUN2,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic acc_en;
        logic sq_load;
        logic sq_sel;
        logic sq_step;
        logic r1_store;
        logic mul_en;
        logic div_load;
        logic div_step;
        logic out_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic norm_zero;
        logic out_free;
    } status_t;

endpackage

FILE: src/cde_ctrl.sv
// ----------------------------------------------------------------------------
// cde_ctrl
// Sequencer: accumulate each word; after the last, run root, multiply and divide steps (skipped on a zero norm).
// ----------------------------------------------------------------------------
module cde_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cde_pkg::status_t  status,
    output cde_pkg::cmd_t     cmd
);

    cde_pkg::state_t            state_reg, state_next;
    logic [cde_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    // Hold state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cde_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = (state_reg != cde_pkg::ST_IDLE);
        unique case (state_reg)
            cde_pkg::ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = cde_pkg::ST_ACC;
            end
            cde_pkg::ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = status.last ? cde_pkg::ST_SQ_LOAD1 : cde_pkg::ST_IDLE;
            end
            cde_pkg::ST_SQ_LOAD1:
            begin
                if (status.norm_zero)
                    state_next = cde_pkg::ST_FIN;
                else
                begin
                    cmd.sq_load = 1'b1;
                    cnt_next    = '0;
                    state_next  = cde_pkg::ST_SQ_RUN1;
                end
            end
            cde_pkg::ST_SQ_RUN1:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == cde_pkg::CNT_W'(cde_pkg::SQRT_STEPS - 1))
                    state_next = cde_pkg::ST_SQ_LOAD2;
            end
            cde_pkg::ST_SQ_LOAD2:
            begin
                cmd.r1_store = 1'b1;
                cmd.sq_load  = 1'b1;
                cmd.sq_sel   = 1'b1;
                cnt_next     = '0;
                state_next   = cde_pkg::ST_SQ_RUN2;
            end
            cde_pkg::ST_SQ_RUN2:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == cde_pkg::CNT_W'(cde_pkg::SQRT_STEPS - 1))
                    state_next = cde_pkg::ST_MUL;
            end
            cde_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = cde_pkg::ST_DIV_LOAD;
            end
            cde_pkg::ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = cde_pkg::ST_DIV_RUN;
            end
            cde_pkg::ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == cde_pkg::CNT_W'(cde_pkg::DIV_STEPS - 1))
                    state_next = cde_pkg::ST_FIN;
            end
            cde_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = cde_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cde_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/cde_datapath.sv
// ----------------------------------------------------------------------------
// cde_datapath
// Accumulators, shared square root unit, multiplier, divider, output register.
// ----------------------------------------------------------------------------
module cde_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cde_pkg::cmd_t                cmd,
    output cde_pkg::status_t             status,
    input  logic signed [cde_pkg::ELEM_W-1:0] first_element,
    input  logic signed [cde_pkg::ELEM_W-1:0] second_element,
    input  logic                         last_element,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [15:0]           similarity,
    output logic [15:0]                  dissimilarity,
    output logic                         zero_norm
);

    localparam int EW = cde_pkg::ELEM_W;
    localparam int DW = cde_pkg::DOT_W;
    localparam int NW = cde_pkg::NORM_W;
    localparam int SW = cde_pkg::SQ_W;
    localparam int RW = cde_pkg::ROOT_W;
    localparam int QW = cde_pkg::QUO_W;

    logic signed [EW-1:0]        a_reg, b_reg;
    logic                        last_reg;
    logic signed [DW-1:0]        dot_reg;
    logic [NW-1:0]               n1_reg, n2_reg;
    logic [SW-1:0]               sx_reg, sr_reg, sb_reg;
    logic [RW-1:0]               r1_reg;
    logic [cde_pkg::DEN_W-1:0]   den_reg;
    logic [cde_pkg::REM_W-1:0]   rem_reg;
    logic [QW-1:0]               q_reg;
    logic                        sat_reg, neg_reg;
    logic                        out_valid_reg;
    logic signed [15:0]          sim_reg;
    logic [15:0]                 dis_reg;
    logic                        zero_reg;

    // Products and saturating sums
    logic signed [2*EW-1:0]      p_ab, p_aa, p_bb;
    logic signed [DW:0]          dot_wide;
    logic [NW:0]                 n1_wide, n2_wide;
    logic signed [DW-1:0]        dot_sat;
    logic [NW-1:0]               n1_sat, n2_sat;

    assign p_ab     = a_reg * b_reg;
    assign p_aa     = a_reg * a_reg;
    assign p_bb     = b_reg * b_reg;
    assign dot_wide = {dot_reg[DW-1], dot_reg} + (DW+1)'(p_ab);
    assign n1_wide  = {1'b0, n1_reg} + (NW+1)'($unsigned(p_aa));
    assign n2_wide  = {1'b0, n2_reg} + (NW+1)'($unsigned(p_bb));

    always_comb
    begin
        priority if (dot_wide[DW] != dot_wide[DW-1])
            dot_sat = dot_wide[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            dot_sat = dot_wide[DW-1:0];
        n1_sat = n1_wide[NW] ? {NW{1'b1}} : n1_wide[NW-1:0];
        n2_sat = n2_wide[NW] ? {NW{1'b1}} : n2_wide[NW-1:0];
    end

    // Square root step, one result bit per cycle
    logic [SW:0] sq_trial;
    logic        sq_take;
    assign sq_trial = {1'b0, sr_reg} + {1'b0, sb_reg};
    assign sq_take  = ({1'b0, sx_reg} >= sq_trial);

    // Magnitude of the dot product, pre-scaled for the divider
    logic [DW-1:0] mag;
    logic [SW-1:0] mag_sh;
    assign mag    = dot_reg[DW-1] ? DW'(-dot_reg) : DW'(dot_reg);
    assign mag_sh = {mag[SW-cde_pkg::PRE_SHIFT-1:0], {cde_pkg::PRE_SHIFT{1'b0}}};

    // Divider step
    logic [cde_pkg::REM_W-1:0] div_trial;
    logic                      div_take;
    assign div_trial = {rem_reg[cde_pkg::REM_W-2:0], 1'b0};
    assign div_take  = (div_trial >= {1'b0, den_reg});

    // Round, saturate and form the result word
    logic [QW:0]        q_inc;
    logic [QW-1:0]      m;
    logic [16:0]        m_clip;
    logic signed [17:0] sim_wide;
    logic signed [17:0] dis_wide;
    logic signed [15:0] sim_fin;
    logic [15:0]        dis_fin;

    always_comb
    begin
        q_inc = {1'b0, q_reg} + 1'b1;
        m     = q_inc[QW:1];
        if (neg_reg)
            m_clip = (sat_reg || m > QW'(32768)) ? 17'd32768 : 17'(m);
        else
            m_clip = (sat_reg || m > QW'(32767)) ? 17'd32767 : 17'(m);
        sim_wide = neg_reg ? -$signed({1'b0, m_clip}) : $signed({1'b0, m_clip});
        dis_wide = 18'sd32768 - sim_wide;
        if (status.norm_zero)
        begin
            sim_fin = '0;
            dis_fin = '0;
        end
        else
        begin
            sim_fin = sim_wide[15:0];
            dis_fin = (dis_wide > 18'sd65535) ? 16'hFFFF : dis_wide[15:0];
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg    <= first_element;
            b_reg    <= second_element;
            last_reg <= last_element;
        end
    end

    // Accumulate and clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            n1_reg  <= '0;
            n2_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            dot_reg <= '0;
            n1_reg  <= '0;
            n2_reg  <= '0;
        end
        else if (cmd.acc_en)
        begin
            dot_reg <= dot_sat;
            n1_reg  <= n1_sat;
            n2_reg  <= n2_sat;
        end
    end

    // Iterate the root, multiply and divide
    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
        begin
            sx_reg <= {cmd.sq_sel ? n2_reg : n1_reg, {cde_pkg::SQ_SHIFT{1'b0}}};
            sr_reg <= '0;
            sb_reg <= {1'b1, {(SW-1){1'b0}}};
        end
        else if (cmd.sq_step)
        begin
            if (sq_take)
            begin
                sx_reg <= sx_reg - sq_trial[SW-1:0];
                sr_reg <= (sr_reg >> 1) + sb_reg;
            end
            else
                sr_reg <= sr_reg >> 1;
            sb_reg <= sb_reg >> 2;
        end
        if (cmd.r1_store)
            r1_reg <= sr_reg[RW-1:0];
        if (cmd.mul_en)
            den_reg <= r1_reg * sr_reg[RW-1:0];
        if (cmd.div_load)
        begin
            rem_reg <= {2'b00, mag_sh};
            sat_reg <= ({1'b0, mag_sh} >= den_reg);
            neg_reg <= dot_reg[DW-1];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_take ? (div_trial - {1'b0, den_reg}) : div_trial;
            q_reg   <= {q_reg[QW-2:0], div_take};
        end
        if (cmd.out_load)
        begin
            sim_reg  <= sim_fin;
            dis_reg  <= dis_fin;
            zero_reg <= status.norm_zero;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign status.last      = last_reg;
    assign status.norm_zero = (n1_reg == '0) || (n2_reg == '0);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign similarity    = sim_reg;
    assign dissimilarity = dis_reg;
    assign zero_norm     = zero_reg;

endmodule

FILE: src/cosine_dissimilarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_dissimilarity_engine
// Streaming cosine similarity and dissimilarity of two Q1.15 vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one element pair per word,
//   with last_element marking the final pair of the vectors.
//   Output channel (out_valid / out_stall) carries one result word per
//   vector pair: similarity, dissimilarity and zero_norm.
// Each element word is captured, then multiplied and accumulated in a
//   separate state; in_stall is high while it accumulates.
// After the last word the result passes the sequencer states ACC, SQ_LOAD1,
//   SQ_RUN1, SQ_LOAD2, SQ_RUN2, MUL, DIV_LOAD, DIV_RUN and FIN to out_valid;
//   the bit-serial square root unit runs once per norm and the divider is
//   bit-serial. With a zero norm it goes from SQ_LOAD1 straight to FIN.
// The result register lets new element words be taken while a result waits;
//   only the final step of the next vector waits on a stalled receiver.
// Reset clears the accumulators, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module cosine_dissimilarity_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] first_element,
    input  logic signed [15:0] second_element,
    input  logic               last_element,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] similarity,
    output logic [15:0]        dissimilarity,
    output logic               zero_norm
);

    cde_pkg::cmd_t    cmd;
    cde_pkg::status_t status;

    // Sequencer
    cde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic
    cde_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .first_element  (first_element),
        .second_element (second_element),
        .last_element   (last_element),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .similarity     (similarity),
        .dissimilarity  (dissimilarity),
        .zero_norm      (zero_norm)
    );

endmodule

FILE: src/cde_checker.sv
// ----------------------------------------------------------------------------
// cde_checker
// Port-level checks of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "cosine_dissimilarity_engine_macros.svh"

module cde_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] similarity,
    input logic [15:0]        dissimilarity,
    input logic               zero_norm
);

    logic        out_wait;
    logic [15:0] dis_expect;

    // Form the waiting condition and the dissimilarity implied by similarity
    assign out_wait   = out_valid && out_stall;
    assign dis_expect = (similarity == -16'sd32768) ? 16'hFFFF
                      : 16'(17'd32768 - 17'(similarity));

    // Hold a stalled result
    `CDE_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(similarity), "stalled word lost")

    // Block the word after an accepted one while it accumulates
    `CDE_ASSERT_NEXT(a_in_gap, in_valid && !in_stall, in_stall, "word accepted back to back")

    // Drive zeros on a zero norm
    `CDE_ASSERT_SAME(a_zero, out_valid && zero_norm, {similarity, dissimilarity} == '0, "nonzero")

    // Keep dissimilarity consistent with similarity
    `CDE_ASSERT_SAME(a_dis, out_valid && !zero_norm, dissimilarity == dis_expect, "dis mismatch")

endmodule

bind cosine_dissimilarity_engine cde_checker u_cde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .similarity    (similarity),
    .dissimilarity (dissimilarity),
    .zero_norm     (zero_norm)
);
